### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/sck_pkg.sv
// ----------------------------------------------------------------------------
// sck_pkg
// Keymap tables, command type and helpers shared by the keymap modules.
// ----------------------------------------------------------------------------
package sck_pkg;

  localparam int unsigned TABLE_SIZE = 86;
  localparam int unsigned IDX_W      = 7;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Special entries above the ASCII range.
  localparam logic [7:0] SP_CTRL = 8'h80;
  localparam logic [7:0] SP_SHFT = 8'h81;
  localparam logic [7:0] SP_ALT  = 8'h82;
  localparam logic [7:0] SP_CAPS = 8'h83;
  localparam logic [7:0] SP_FUNC = 8'h84;
  localparam logic [7:0] SP_HOME = 8'h90;
  localparam logic [7:0] SP_UP   = 8'h91;
  localparam logic [7:0] SP_PGUP = 8'h92;
  localparam logic [7:0] SP_LEFT = 8'h93;
  localparam logic [7:0] SP_RGHT = 8'h94;
  localparam logic [7:0] SP_END  = 8'h95;
  localparam logic [7:0] SP_DOWN = 8'h96;
  localparam logic [7:0] SP_PGDN = 8'h97;
  localparam logic [7:0] SP_INS  = 8'h98;

  // Byte positions inside an escape sequence.
  localparam logic [1:0] POS_TAIL  = 2'd2;
  localparam logic [1:0] POS_TILDE = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_CSI3 = 2'd2,
    KIND_CSI4 = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;   // character, or tail letter/digit of a sequence
  } cmd_t;

  localparam logic [7:0] PLAIN_TAB [0:TABLE_SIZE-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h80, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h81, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h81, 8'h2A,
    8'h82, 8'h20, 8'h83, 8'h84, 8'h84, 8'h84, 8'h84, 8'h84,
    8'h84, 8'h84, 8'h84, 8'h84, 8'h84, 8'h00, 8'h00, 8'h90,
    8'h91, 8'h92, 8'h00, 8'h93, 8'h00, 8'h94, 8'h00, 8'h95,
    8'h96, 8'h97, 8'h98, 8'h7F, 8'h84, 8'h84
  };

  localparam logic [7:0] SHIFT_TAB [0:TABLE_SIZE-1] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h80, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h82, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h90,
    8'h91, 8'h92, 8'h00, 8'h93, 8'h00, 8'h94, 8'h00, 8'h95,
    8'h96, 8'h97, 8'h98, 8'h7F, 8'h00, 8'h00
  };

  // Map a table entry to a command.
  function automatic cmd_t classify(input logic [7:0] ent);
    cmd_t c;
    c.kind = KIND_NONE;
    c.val  = ent;
    unique case (ent)
      SP_CTRL, SP_SHFT, SP_ALT, SP_CAPS, SP_FUNC: c.kind = KIND_NONE;
      SP_HOME: begin c.kind = KIND_CSI3; c.val = 8'h48; end
      SP_END:  begin c.kind = KIND_CSI3; c.val = 8'h46; end
      SP_UP:   begin c.kind = KIND_CSI3; c.val = 8'h41; end
      SP_DOWN: begin c.kind = KIND_CSI3; c.val = 8'h42; end
      SP_LEFT: begin c.kind = KIND_CSI3; c.val = 8'h44; end
      SP_RGHT: begin c.kind = KIND_CSI3; c.val = 8'h43; end
      SP_INS:  begin c.kind = KIND_CSI4; c.val = 8'h32; end
      SP_PGUP: begin c.kind = KIND_CSI4; c.val = 8'h35; end
      SP_PGDN: begin c.kind = KIND_CSI4; c.val = 8'h36; end
      default: begin
        if (!ent[7] && (ent != 8'h00)) begin
          c.kind = KIND_CHAR;
        end
      end
    endcase
    return c;
  endfunction

  // Byte at position pos of the sequence for command c.
  function automatic logic [7:0] seq_byte(input cmd_t c, input logic [1:0] pos);
    logic [7:0] b;
    b = c.val;
    if (c.kind != KIND_CHAR) begin
      unique case (pos)
        2'd0:      b = CH_ESC;
        2'd1:      b = CH_LBRK;
        POS_TAIL:  b = c.val;
        POS_TILDE: b = CH_TILDE;
        default:   b = c.val;
      endcase
    end
    return b;
  endfunction

  function automatic logic seq_last(input cmd_t c, input logic [1:0] pos);
    return (c.kind == KIND_CHAR) || (c.kind == KIND_NONE) ||
           ((c.kind == KIND_CSI3) && (pos == POS_TAIL)) ||
           (pos == POS_TILDE);
  endfunction

endpackage

### hdl/sck_front.sv
// ----------------------------------------------------------------------------
// sck_front
// Looks up the scan code, classifies it and registers one command per key
// that produces output; keys that produce nothing are dropped here.
// ----------------------------------------------------------------------------
module sck_front
  import sck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [15:0] scan_code,
  input  logic        shift_held,
  output logic        full,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_ready
);

  logic             in_ready;
  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic [7:0]       ent;
  cmd_t             cls;

  assign in_ready = !cmd_valid || cmd_ready;
  assign full     = !in_ready;

  assign in_range = (scan_code < 16'(TABLE_SIZE));
  assign idx      = scan_code[IDX_W-1:0];

  always_comb begin
    ent = 8'h00;
    if (in_range) begin
      ent = shift_held ? SHIFT_TAB[idx] : PLAIN_TAB[idx];
    end
    cls = classify(ent);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= push && (cls.kind != KIND_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (push && in_ready) begin
      cmd <= cls;
    end
  end

endmodule

### hdl/sck_queue.sv
// ----------------------------------------------------------------------------
// sck_queue
// Small register queue of commands between front and back.
// ----------------------------------------------------------------------------
module sck_queue
  import sck_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  cmd_t wr_cmd,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_cmd,
  input  logic rd_pop
);

  cmd_t              slots [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

### hdl/sck_back.sv
// ----------------------------------------------------------------------------
// sck_back
// Expands queued commands into output bytes, one per cycle unless pop stalls it.
// ----------------------------------------------------------------------------
module sck_back
  import sck_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] ascii_byte,
  output logic       last_byte,
  output logic [1:0] seq_idx
);

  logic out_valid;
  logic take;
  logic is_last;

  assign empty   = !out_valid;
  assign take    = cmd_valid && (!out_valid || pop);
  assign is_last = seq_last(cmd, seq_idx);
  assign cmd_pop = take && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seq_idx   <= 2'd0;
    end else if (take) begin
      out_valid <= 1'b1;
      seq_idx   <= is_last ? 2'd0 : seq_idx + 2'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ascii_byte <= seq_byte(cmd, seq_idx);
      last_byte  <= is_last;
    end
  end

endmodule

### hdl/scancode_to_ascii_keymap_top.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_keymap_top
// Set-1 make code plus shift flag in, ASCII byte stream out.
// ----------------------------------------------------------------------------
// Path: an accepted key is registered in the front stage, then written into
//   the queue, then its first byte is loaded into the output register.
// Throughput: one push per cycle at the front while full is low; the back
//   emits one byte per cycle while its output is empty or popped. A key yields
//   1 byte (printable), 3 (arrows, home, end), 4 (ins, page up/down) or none.
// Reset: synchronous rst empties the front stage, queue and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scancode_to_ascii_keymap_top
  import sck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input side
  input  logic        push,
  output logic        full,
  input  logic [15:0] scan_code,
  input  logic        shift_held,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  ascii_byte,
  output logic        last_byte
);

  // front -> queue
  logic f_valid;
  cmd_t f_cmd;
  logic f_ready;

  // queue -> back
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  logic [1:0] seq_idx;

  // Front: table lookup and classification, drops keys with no bytes.
  sck_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .scan_code  (scan_code),
    .shift_held (shift_held),
    .full       (full),
    .cmd_valid  (f_valid),
    .cmd        (f_cmd),
    .cmd_ready  (f_ready)
  );

  // Decoupling queue: front keeps taking keys while the back spells out
  // a multi-byte sequence.
  sck_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_cmd   (f_cmd),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .rd_pop   (q_pop)
  );

  // Back: byte sequencer feeding the output register; a command leaves the
  // queue only when its last byte is loaded.
  sck_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .ascii_byte (ascii_byte),
    .last_byte  (last_byte),
    .seq_idx    (seq_idx)
  );

  // A code past the table never reaches the queue.
  `ASSERT_NEXT(a_oob_dropped, clk, rst, push && !full && (scan_code >= 16'(TABLE_SIZE)), !f_valid)
  // Mid-sequence, the command being spelled is still at the queue head.
  `ASSERT_IMPL(a_seq_holds_cmd, clk, rst, seq_idx != 2'd0, q_valid)
  // A non-final byte on the ports means the sequencer is mid-sequence.
  `ASSERT_IMPL(a_nonlast_mid_seq, clk, rst, !empty && !last_byte, seq_idx != 2'd0)

endmodule

### test/scancode_to_ascii_keymap_top_tb.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_keymap_top_tb
// Self-checking bench: key transactions in, ASCII byte transactions out.
// A local copy of both keymaps predicts every byte, which is checked in order.
// Both sides idle at random, and the result side stops for a long stretch once.
// ----------------------------------------------------------------------------
module scancode_to_ascii_keymap_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Entry codes above the ASCII range.
  localparam logic [7:0] KC_CTRL = 8'h80;
  localparam logic [7:0] KC_SHFT = 8'h81;
  localparam logic [7:0] KC_ALT  = 8'h82;
  localparam logic [7:0] KC_CAPS = 8'h83;
  localparam logic [7:0] KC_FUNC = 8'h84;
  localparam logic [7:0] KC_HOME = 8'h90;
  localparam logic [7:0] KC_UP   = 8'h91;
  localparam logic [7:0] KC_PGUP = 8'h92;
  localparam logic [7:0] KC_LEFT = 8'h93;
  localparam logic [7:0] KC_RGHT = 8'h94;
  localparam logic [7:0] KC_END  = 8'h95;
  localparam logic [7:0] KC_DOWN = 8'h96;
  localparam logic [7:0] KC_PGDN = 8'h97;
  localparam logic [7:0] KC_INS  = 8'h98;

  localparam logic [7:0] SEQ_ESC   = 8'h1B;
  localparam logic [7:0] SEQ_LBRK  = 8'h5B;
  localparam logic [7:0] SEQ_TILDE = 8'h7E;

  localparam int MAP_SIZE   = 86;
  localparam int KEY_TARGET = 180;   // total keys offered, directed ones included
  localparam int HOLD_LEN   = 150;   // long result-side stall, in cycles

  localparam logic [7:0] UNSHIFTED_MAP [0:MAP_SIZE-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, KC_CTRL, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, KC_SHFT, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, KC_SHFT, 8'h2A,
    KC_ALT, 8'h20, KC_CAPS, KC_FUNC, KC_FUNC, KC_FUNC, KC_FUNC, KC_FUNC,
    KC_FUNC, KC_FUNC, KC_FUNC, KC_FUNC, KC_FUNC, 8'h00, 8'h00, KC_HOME,
    KC_UP, KC_PGUP, 8'h00, KC_LEFT, 8'h00, KC_RGHT, 8'h00, KC_END,
    KC_DOWN, KC_PGDN, KC_INS, 8'h7F, KC_FUNC, KC_FUNC
  };

  localparam logic [7:0] SHIFTED_MAP [0:MAP_SIZE-1] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, KC_CTRL, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    KC_ALT, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, KC_HOME,
    KC_UP, KC_PGUP, 8'h00, KC_LEFT, 8'h00, KC_RGHT, 8'h00, KC_END,
    KC_DOWN, KC_PGDN, KC_INS, 8'h7F, 8'h00, 8'h00
  };

  typedef struct {
    logic [15:0] code;
    logic        shift;
  } key_event_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } key_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] scan_code = '0;
  logic        shift_held = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  ascii_byte;
  logic        last_byte;

  key_event_t key_queue[$];        // keys waiting to be offered
  key_byte_t  expected_bytes[$];   // bytes predicted, oldest first
  int         keys_accepted = 0;
  int         mismatches = 0;
  bit         hold_off = 1'b0;     // long stall on the result side
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  int         tx_gap = 0;
  int         rx_gap = 0;

  scancode_to_ascii_keymap_top dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .scan_code  (scan_code),
    .shift_held (shift_held),
    .empty      (empty),
    .pop        (pop),
    .ascii_byte (ascii_byte),
    .last_byte  (last_byte)
  );

  always #10 clk = ~clk;

  // Appends the bytes one key produces to seq and returns how many.
  // Silent keys: past the map, empty entries, modifiers, function keys.
  // Caps lock is deliberately not folded into letters.
  function automatic int translate_key(input logic [15:0] code, input logic shift,
                                       ref key_byte_t seq[$]);
    logic [7:0] ent;
    logic [7:0] tail;
    logic       csi4;
    if (code >= MAP_SIZE) return 0;
    ent  = shift ? SHIFTED_MAP[code[6:0]] : UNSHIFTED_MAP[code[6:0]];
    tail = 8'h00;
    csi4 = 1'b0;
    case (ent)
      8'h00, KC_CTRL, KC_SHFT, KC_ALT, KC_CAPS, KC_FUNC: return 0;
      KC_HOME: tail = 8'h48;   // 'H'
      KC_END:  tail = 8'h46;   // 'F'
      KC_UP:   tail = 8'h41;   // 'A'
      KC_DOWN: tail = 8'h42;   // 'B'
      KC_LEFT: tail = 8'h44;   // 'D'
      KC_RGHT: tail = 8'h43;   // 'C'
      KC_INS:  begin tail = 8'h32; csi4 = 1'b1; end   // '2'
      KC_PGUP: begin tail = 8'h35; csi4 = 1'b1; end   // '5'
      KC_PGDN: begin tail = 8'h36; csi4 = 1'b1; end   // '6'
      default: begin
        seq.push_back('{ch: ent, last: 1'b1});
        return 1;
      end
    endcase
    // ESC [ tail, plus '~' for the four-byte keys; last flag on the final byte
    seq.push_back('{ch: SEQ_ESC, last: 1'b0});
    seq.push_back('{ch: SEQ_LBRK, last: 1'b0});
    seq.push_back('{ch: tail, last: !csi4});
    if (!csi4) return 3;
    seq.push_back('{ch: SEQ_TILDE, last: 1'b1});
    return 4;
  endfunction

  // Idle length after a transaction: mostly none, some short, a few long.
  // Now and then a side flips into a steady run with no idling at all.
  function automatic int pick_gap(ref bit steady);
    int r;
    r = $urandom_range(99);
    if (r < 3) steady = !steady;
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Key side: offer the next key; it is taken when push is high and full is
  // low at an edge. The prediction is made at that edge, so the expected bytes
  // are queued in the exact order the block accepts keys.
  always @(posedge clk) begin : drive_keys
    key_event_t nxt;
    bit         taken;
    if (!rst) begin
      taken = push && !full;
      if (taken) begin
        void'(translate_key(scan_code, shift_held, expected_bytes));
        keys_accepted++;
        tx_gap = pick_gap(tx_steady);
      end
      // Hold the current key while it waits; otherwise decide what comes next.
      if (!push || taken) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (key_queue.size() > 0) begin
          nxt = key_queue.pop_front();
          scan_code  <= nxt.code;
          shift_held <= nxt.shift;
          push       <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Byte side: every accepted byte is compared with the oldest prediction.
  always @(posedge clk) begin : check_bytes
    key_byte_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: ascii_byte=%h last_byte=%b", ascii_byte, last_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (ascii_byte !== want.ch) begin
            $error("ascii_byte: expected %h, actual %h", want.ch, ascii_byte);
            mismatches++;
          end
          if (last_byte !== want.last) begin
            $error("last_byte: expected %b, actual %b", want.last, last_byte);
            mismatches++;
          end
        end
        rx_gap = pick_gap(rx_steady);
      end
      if (hold_off) begin
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Once traffic is flowing, stop reading for a long stretch while keys keep
  // coming, so the internal queue fills and full pushes back on the key side.
  initial begin : back_pressure
    while (keys_accepted < 40) @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    key_event_t ev;
    int r;

    // Directed keys: map edges, every entry kind, silent keys, codes past the map.
    key_queue.push_back('{16'd0, 1'b0});      // empty entry
    key_queue.push_back('{16'd1, 1'b0});      // escape key
    key_queue.push_back('{16'd2, 1'b0});
    key_queue.push_back('{16'd2, 1'b1});      // shifted digit row
    key_queue.push_back('{16'd30, 1'b0});
    key_queue.push_back('{16'd30, 1'b1});     // shifted letter
    key_queue.push_back('{16'd29, 1'b0});     // ctrl
    key_queue.push_back('{16'd42, 1'b0});     // left shift
    key_queue.push_back('{16'd56, 1'b1});     // alt
    key_queue.push_back('{16'd58, 1'b0});     // caps lock, not applied
    key_queue.push_back('{16'd59, 1'b0});     // F1
    key_queue.push_back('{16'd85, 1'b0});     // last map entry, F12
    key_queue.push_back('{16'd83, 1'b1});     // delete
    key_queue.push_back('{16'd71, 1'b0});     // home
    key_queue.push_back('{16'd72, 1'b1});     // up
    key_queue.push_back('{16'd73, 1'b0});     // page up
    key_queue.push_back('{16'd75, 1'b0});     // left
    key_queue.push_back('{16'd77, 1'b1});     // right
    key_queue.push_back('{16'd79, 1'b0});     // end
    key_queue.push_back('{16'd80, 1'b0});     // down
    key_queue.push_back('{16'd81, 1'b1});     // page down
    key_queue.push_back('{16'd82, 1'b0});     // insert
    key_queue.push_back('{16'd86, 1'b0});     // first code past the map
    key_queue.push_back('{16'hFFFF, 1'b1});
    key_queue.push_back('{16'h8000, 1'b0});

    // Random keys: mostly inside the map, some just past it, some full range
    // so every code bit toggles.
    while (key_queue.size() < KEY_TARGET) begin
      r = $urandom_range(99);
      if (r < 75) ev.code = 16'($urandom_range(MAP_SIZE - 1));
      else if (r < 85) ev.code = 16'($urandom_range(127, MAP_SIZE));
      else ev.code = 16'($urandom);
      ev.shift = 1'($urandom);
      key_queue.push_back(ev);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: all keys taken, every predicted byte seen, then a quiet tail
    // to catch stray bytes from keys still in flight.
    while (key_queue.size() != 0 || push) @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("scancode_to_ascii_keymap_top test passed");
    end else begin
      $display("scancode_to_ascii_keymap_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("scancode_to_ascii_keymap_top test failed");
    $finish;
  end

endmodule
